/* rtl/core/greedy_box_nms_defines.svh */
`ifndef GREEDY_BOX_NMS_DEFINES_SVH
`define GREEDY_BOX_NMS_DEFINES_SVH

// Check an implication at every clock edge outside reset.
`define GBN_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition never occurs outside reset.
`define GBN_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/gbn_pkg.sv */
package gbn_pkg;

	localparam int MAX_PICKED  = 64;
	localparam int COORD_BITS  = 16;
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int THR_BITS    = 16;
	localparam int INDEX_BITS  = 16;
	localparam int KCOUNT_BITS = 7;

	localparam int PICK_AW  = $clog2(MAX_PICKED);
	localparam int PICK_CW  = $clog2(MAX_PICKED + 1);
	localparam int EDGE_W   = COORD_BITS + 2;
	localparam int PROD_W   = 2 * SIZE_BITS;
	localparam int UNION_W  = PROD_W + 1;
	localparam int CMP_W    = UNION_W + THR_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [THR_BITS-1:0]   THR_RESET = 16'd29491;
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

	typedef struct packed {
		logic                         start_of_set;
		logic signed [COORD_BITS-1:0] box_x;
		logic signed [COORD_BITS-1:0] box_y;
		logic [SIZE_BITS-1:0]         box_width;
		logic [SIZE_BITS-1:0]         box_height;
	} cand_t;

	typedef struct packed {
		logic                   keep;
		logic [INDEX_BITS-1:0]  item_index;
		logic                   list_full;
		logic [KCOUNT_BITS-1:0] kept_count;
	} res_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [SIZE_BITS-1:0]         w;
		logic [SIZE_BITS-1:0]         h;
	} box_t;

	typedef struct packed {
		logic              start;
		box_t              box;
		logic [PROD_W-1:0] area;
	} q_ent_t;

	typedef struct packed {
		logic   valid;
		q_ent_t ent;
	} q_head_t;

	typedef struct packed {
		logic hit;
		logic busy;
	} iou_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage

/* rtl/core/gbn_front.sv */
module gbn_front import gbn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cand_valid,
	output logic    cand_stall,
	input  cand_t   cand,
	output q_head_t head,
	input  logic    pop
);

	q_ent_t              q_mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                push;
	q_ent_t              ent_in;

	assign cand_stall = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign push       = cand_valid && !cand_stall;

	// Classify the incoming word: set start and own area.
	always_comb begin
		ent_in.start = cand.start_of_set;
		ent_in.box.x = cand.box_x;
		ent_in.box.y = cand.box_y;
		ent_in.box.w = cand.box_width;
		ent_in.box.h = cand.box_height;
		ent_in.area  = cand.box_width * cand.box_height;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.ent   = q_mem[rd_q];

endmodule

/* rtl/core/gbn_iou.sv */
module gbn_iou import gbn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  box_t                a_box,
	input  logic [PROD_W-1:0]   a_area,
	input  box_t                b_box_s1,
	input  logic [THR_BITS-1:0] thr,
	output iou_stat_t           stat
);

	logic                      valid_s2, valid_s3, valid_s4, valid_s5;
	logic [SIZE_BITS-1:0]      ow_s2, oh_s2, bw_s2, bh_s2;
	logic [PROD_W-1:0]         inter_s3, areab_s3, inter_s4;
	logic [UNION_W-1:0]        uni_s4;
	logic [CMP_W-1:0]          rhs_s5;
	logic [CMP_W-1:0]          lhs_s5;

	logic signed [EDGE_W-1:0]  ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
	logic signed [EDGE_W-1:0]  dx, dy;
	logic [SIZE_BITS-1:0]      ow, oh;

	// Overlap along each axis, clamped at zero; never exceeds the narrower size.
	always_comb begin
		ax0 = EDGE_W'(a_box.x);
		bx0 = EDGE_W'(b_box_s1.x);
		ay0 = EDGE_W'(a_box.y);
		by0 = EDGE_W'(b_box_s1.y);
		ax1 = ax0 + $signed({{(EDGE_W-SIZE_BITS){1'b0}}, a_box.w});
		bx1 = bx0 + $signed({{(EDGE_W-SIZE_BITS){1'b0}}, b_box_s1.w});
		ay1 = ay0 + $signed({{(EDGE_W-SIZE_BITS){1'b0}}, a_box.h});
		by1 = by0 + $signed({{(EDGE_W-SIZE_BITS){1'b0}}, b_box_s1.h});
		dx  = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
		dy  = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
		ow  = (dx > 0) ? dx[SIZE_BITS-1:0] : '0;
		oh  = (dy > 0) ? dy[SIZE_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ow_s2    <= ow;
		oh_s2    <= oh;
		bw_s2    <= b_box_s1.w;
		bh_s2    <= b_box_s1.h;
		inter_s3 <= ow_s2 * oh_s2;
		areab_s3 <= bw_s2 * bh_s2;
		inter_s4 <= inter_s3;
		uni_s4   <= UNION_W'(a_area) + UNION_W'(areab_s3) - UNION_W'(inter_s3);
		rhs_s5   <= uni_s4 * thr;
		lhs_s5   <= {1'b0, inter_s4, {THR_BITS{1'b0}}};
	end

	assign stat.hit  = valid_s5 && (lhs_s5 > rhs_s5);
	assign stat.busy = valid_s2 || valid_s3 || valid_s4 || valid_s5;

endmodule

/* rtl/core/gbn_back.sv */
module gbn_back import gbn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  q_head_t             head,
	output logic                pop,
	input  logic [THR_BITS-1:0] thr,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res
);

	back_state_t             state_q;
	q_ent_t                  cur_q;
	logic [PICK_CW-1:0]      scan_q;
	logic [PICK_CW-1:0]      cnt_q;
	logic [INDEX_BITS-1:0]   item_q;
	logic                    sup_q;
	logic                    res_valid_q;
	res_t                    res_q;

	box_t                    mem [MAX_PICKED];
	box_t                    rdata_s1;
	logic                    rvalid_s1;

	logic                    issue;
	logic                    drained;
	logic                    finish;
	logic                    keep;
	logic                    full;
	logic                    store;
	iou_stat_t               iou_stat;

	assign pop     = head.valid && (state_q == ST_IDLE);
	assign issue   = (state_q == ST_SCAN) && (scan_q < cnt_q);
	assign drained = (state_q == ST_SCAN) && !issue && !rvalid_s1 && !iou_stat.busy;
	assign finish  = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	assign keep    = !sup_q;
	assign full    = keep && (cnt_q == PICK_CW'(MAX_PICKED));
	assign store   = finish && keep && !full;

	gbn_iou u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (rvalid_s1),
		.a_box    (cur_q.box),
		.a_area   (cur_q.area),
		.b_box_s1 (rdata_s1),
		.thr      (thr),
		.stat     (iou_stat)
	);

	// Picked list: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store) begin
			mem[cnt_q[PICK_AW-1:0]] <= cur_q.box;
		end
		if (issue) begin
			rdata_s1 <= mem[scan_q[PICK_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.ent;
		end
		if (finish) begin
			res_q.keep       <= keep;
			res_q.item_index <= item_q;
			res_q.list_full  <= full;
			res_q.kept_count <= KCOUNT_BITS'(store ? cnt_q + 1'b1 : cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			cnt_q       <= '0;
			item_q      <= '0;
			sup_q       <= 1'b0;
			rvalid_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (iou_stat.hit) begin
				sup_q <= 1'b1;
			end
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						// Clear the list and the index when the word starts a new set.
						scan_q  <= '0;
						sup_q   <= 1'b0;
						state_q <= ST_SCAN;
						if (head.ent.start) begin
							cnt_q  <= '0;
							item_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (drained) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						if (store) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (item_q != INDEX_MAX) begin
							item_q <= item_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/core/greedy_box_nms.sv */
// Greedy non-maximum suppression over boxes that arrive sorted by falling
// score. Each box word is tested against every box picked so far in its set;
// it is suppressed when inter * 65536 > iou_threshold * union for any picked
// box, otherwise it is reported as kept and appended to the picked list (up
// to 64 boxes; beyond that a survivor is still kept but flagged list_full
// and not stored). A word with start_of_set high clears the list and the
// item index first. Boxes are decided one at a time: the single read port
// of the picked-list memory is walked one entry per cycle over the stored
// boxes, followed by the drain of the five-stage overlap and compare
// pipeline. A two-word queue at the input takes new boxes while one is
// being worked on, and the result register holds a finished word while the
// next box is processed. The threshold port is always ready; write it only
// while no box is in flight.

`include "greedy_box_nms_defines.svh"

module greedy_box_nms import gbn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cand_valid,
	output logic                cand_stall,
	input  cand_t               cand,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THR_BITS-1:0] cfg_data
);

	logic [THR_BITS-1:0] thr_q;
	q_head_t             head;
	logic                pop;

	// Threshold register, Q0.16; resets to 0.45.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Front: accept and classify candidate words into a short queue.
	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.cand       (cand),
		.head       (head),
		.pop        (pop)
	);

	// Back: walk the picked list, decide, store and report.
	gbn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.thr       (thr_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// The first box of a set meets an empty list, so it is always kept and stored.
	`GBN_ASSERT_IMPL(a_first_kept, res_valid && res.item_index == '0, res.keep && res.kept_count == 7'd1, "first box of a set not stored")

	// A full-list flag only ever goes with a kept box and a full list.
	`GBN_ASSERT_IMPL(a_full_kept, res_valid && res.list_full, res.keep && res.kept_count == KCOUNT_BITS'(MAX_PICKED), "list_full without a kept box on a full list")

	// The stored count stays within the list once a set has begun.
	`GBN_ASSERT_NEVER(a_count_range, res_valid && (res.kept_count == '0 || res.kept_count > KCOUNT_BITS'(MAX_PICKED)), "kept_count out of range")

endmodule

/* verif/nms_checker.sv */
module nms_checker import gbn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cand_valid,
	input  logic                cand_stall,
	input  cand_t               cand,
	input  logic                res_valid,
	input  logic                res_stall,
	input  res_t                res,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [THR_BITS-1:0] cfg_data,
	output int                  fail_count,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	box_t                  picked_list [MAX_PICKED];
	int                    picked_total;
	logic [INDEX_BITS-1:0] next_index;
	logic [THR_BITS-1:0]   threshold;
	res_t                  expected_verdicts [$];
	res_t                  oldest;

	function automatic longint overlap_span(longint a0, longint aw, longint b0, longint bw);
		longint lo;
		longint hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + aw < b0 + bw) ? a0 + aw : b0 + bw;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic bit box_suppresses(box_t cur, box_t kept_box);
		longint ow;
		longint oh;
		longint inter;
		longint uni;
		ow = overlap_span($signed(cur.x), cur.w, $signed(kept_box.x), kept_box.w);
		oh = overlap_span($signed(cur.y), cur.h, $signed(kept_box.y), kept_box.h);
		inter = ow * oh;
		uni = longint'(cur.w) * longint'(cur.h) + longint'(kept_box.w) * longint'(kept_box.h)
			- inter;
		return (inter * 65536) > (uni * longint'(threshold));
	endfunction

	function automatic res_t predict_verdict(cand_t c);
		box_t incoming;
		res_t v;
		bit   survives;
		int   i;
		if (c.start_of_set) begin
			picked_total = 0;
			next_index = '0;
		end
		incoming.x = c.box_x;
		incoming.y = c.box_y;
		incoming.w = c.box_width;
		incoming.h = c.box_height;
		survives = 1'b1;
		for (i = 0; i < picked_total && survives; i++) begin
			if (box_suppresses(incoming, picked_list[i]))
				survives = 1'b0;
		end
		v.keep = survives;
		v.list_full = 1'b0;
		if (survives) begin
			if (picked_total < MAX_PICKED) begin
				picked_list[picked_total] = incoming;
				picked_total++;
			end else begin
				v.list_full = 1'b1;
			end
		end
		v.item_index = next_index;
		if (next_index != INDEX_MAX)
			next_index++;
		v.kept_count = KCOUNT_BITS'(picked_total);
		return v;
	endfunction

	task automatic report_field(string field, longint want, longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			picked_total = 0;
			next_index = '0;
			threshold = THR_RESET;
			expected_verdicts.delete();
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_verdicts.size() == 0) begin
					fail_count++;
					$display("%0t: result mismatch, expected no word, got keep=%0d index=%0d",
						$time, res.keep, res.item_index);
				end else begin
					oldest = expected_verdicts.pop_front();
					report_field("keep", oldest.keep, res.keep);
					report_field("item_index", oldest.item_index, res.item_index);
					report_field("list_full", oldest.list_full, res.list_full);
					report_field("kept_count", oldest.kept_count, res.kept_count);
				end
			end
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (cand_valid && !cand_stall)
				expected_verdicts.insert(expected_verdicts.size(), predict_verdict(cand));
			outstanding = expected_verdicts.size();
		end
	end

endmodule

/* verif/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	// The limit leaves a correct run ample room even if every box met a full
	// list under the longest stalls.
	localparam int LIMIT_CYCLES   = 500_000;
	localparam int HOLD_CYCLES    = 200;
	localparam int PHASE_ITEMS    = 60;
	// Settle at the end for longer than the worst box takes.
	localparam int SETTLE_CYCLES  = 100;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cand_valid = 1'b0;
	logic                cand_stall;
	cand_t               cand = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [THR_BITS-1:0] cfg_data = '0;

	int fail_count;
	int outstanding;

	// Idling switches for both sides, set per phase by the stimulus.
	bit sender_idles;
	bit receiver_idles;
	// Long receiver hold-offs: the stimulus asks, the receiver process serves.
	int holds_asked;
	int holds_granted;
	int gap_left;
	int boxes_sent;

	greedy_box_nms u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.cand       (cand),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	nms_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Give up on a hang.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("testbench failed");
		$finish;
	end

	// Result side: drive stall at the falling edge. A pending hold-off request
	// stalls for a long stretch; otherwise, while the receiver idles, stall in short random bursts.
	always begin
		@(negedge clk);
		if (holds_granted != holds_asked) begin
			res_stall = 1'b1;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			holds_granted++;
		end else if (gap_left > 0) begin
			res_stall = 1'b1;
			gap_left--;
		end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
			res_stall = 1'b1;
			gap_left = $urandom_range(0, 4);
		end else begin
			res_stall = 1'b0;
		end
	end

	function automatic cand_t make_box(bit s, int x, int y, int w, int h);
		cand_t c;
		c.start_of_set = s;
		c.box_x = x[COORD_BITS-1:0];
		c.box_y = y[COORD_BITS-1:0];
		c.box_width = w[SIZE_BITS-1:0];
		c.box_height = h[SIZE_BITS-1:0];
		return c;
	endfunction

	// Place a box in one tile of a 16 x 16 grid of 2048-unit tiles; boxes in
	// distinct tiles never overlap, so they are all kept.
	function automatic cand_t grid_box(int slot);
		return make_box(1'b0,
			(slot % 16) * 2048 - 32768 + int'($urandom_range(0, 32)),
			((slot / 16) % 16) * 2048 - 32768 + int'($urandom_range(0, 32)),
			int'($urandom_range(16, 2000)), int'($urandom_range(16, 2000)));
	endfunction

	// Jitter an earlier box by up to about an eighth of its size, so that the
	// overlap lands on both sides of most thresholds.
	function automatic cand_t near_box(cand_t anchor);
		int sx;
		int sy;
		int w;
		int h;
		sx = int'(anchor.box_width) / 8 + 2;
		sy = int'(anchor.box_height) / 8 + 2;
		w = int'(anchor.box_width) + int'($urandom_range(0, 2 * sx)) - sx;
		h = int'(anchor.box_height) + int'($urandom_range(0, 2 * sy)) - sy;
		w = (w < 0) ? 0 : (w > 32767) ? 32767 : w;
		h = (h < 0) ? 0 : (h > 32767) ? 32767 : h;
		return make_box(1'b0,
			int'(anchor.box_x) + int'($urandom_range(0, 2 * sx)) - sx,
			int'(anchor.box_y) + int'($urandom_range(0, 2 * sy)) - sy, w, h);
	endfunction

	function automatic cand_t rand_box();
		return make_box(1'b0, int'($urandom()), int'($urandom()),
			int'($urandom()), int'($urandom()));
	endfunction

	// Offer one word and hold it until it is taken. Entered and left at a
	// falling edge; valid stays high so the next word can follow at once.
	task automatic offer_box(cand_t c);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			cand_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cand_valid = 1'b1;
		cand = c;
		do
			@(posedge clk);
		while (cand_stall);
		boxes_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_drained();
		cand_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_BITS-1:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One frame of mostly clustered boxes: jittered copies of earlier boxes
	// for suppression, fresh tiles for survivors, some wild boxes and some
	// degenerate ones. Now and then break the frame with a stray start flag.
	task automatic run_mixed_set(int n);
		cand_t sent [$];
		cand_t c;
		int    pick;
		int    i;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (sent.size() == 0 || (pick >= 45 && pick < 75)) begin
				c = grid_box($urandom_range(0, 255));
			end else if (pick < 45) begin
				c = near_box(sent[$urandom_range(0, sent.size() - 1)]);
			end else if (pick < 90) begin
				c = rand_box();
			end else begin
				c = near_box(sent[$urandom_range(0, sent.size() - 1)]);
				if (pick[0])
					c.box_width = '0;
				else
					c.box_height = '0;
			end
			c.start_of_set = (i == 0) || ($urandom_range(0, 59) == 0);
			offer_box(c);
			sent.insert(sent.size(), c);
		end
	endtask

	// Push n words through one frame, mostly disjoint boxes so that the list can
	// fill, with repeats mixed in that are suppressed when their original was stored.
	task automatic run_filling_set(int n);
		cand_t stored [$];
		cand_t c;
		int    i;
		for (i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 6) == 0)
				c = stored[$urandom_range(0, stored.size() - 1)];
			else
				c = grid_box(i);
			c.start_of_set = (i == 0);
			offer_box(c);
			stored.insert(stored.size(), c);
		end
	endtask

	initial begin
		logic [THR_BITS-1:0] thr;
		int                  phase;
		int                  first_box;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the reset threshold. The first one carries no
		// start flag, so it relies on the list being empty out of reset.
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		offer_box(make_box(1'b0, 0, 0, 160, 160));
		offer_box(make_box(1'b0, 0, 0, 160, 160));          // identical: suppressed
		offer_box(make_box(1'b0, 32, 0, 160, 160));         // heavy overlap
		offer_box(make_box(1'b0, 96, 0, 160, 160));         // light overlap: kept
		offer_box(make_box(1'b0, 256, 0, 160, 160));        // edges only touch
		offer_box(make_box(1'b0, 1000, 1000, 0, 0));        // empty box
		offer_box(make_box(1'b0, 1000, 1000, 0, 0));        // zero union: kept
		offer_box(make_box(1'b1, -32768, -32768, 32767, 32767));
		offer_box(make_box(1'b0, 32767, 32767, 32767, 32767));
		offer_box(make_box(1'b0, -32768, -32768, 32767, 32767));
		offer_box(make_box(1'b0, -1, -1, 32767, 0));
		offer_box(make_box(1'b0, 0, -32768, 0, 32767));
		offer_box(make_box(1'b1, -100, -100, 1, 1));
		offer_box(make_box(1'b0, -100, -100, 1, 1));

		// Random phases, each at its own threshold, extremes first.
		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0:       thr = '0;
				1:       thr = '1;
				3:       thr = 16'h8000;
				5:       thr = THR_RESET;
				default: thr = THR_BITS'($urandom_range(1, 65534));
			endcase
			write_threshold(thr);
			// Run phase 2 without idling; the last phase has none either.
			sender_idles = (phase != 2) && (phase != 5);
			receiver_idles = sender_idles;
			first_box = boxes_sent;
			if (phase == 1 || phase == 3)
				run_filling_set(80);
			if (phase == 1) begin
				// Hold the result side off while words keep coming, so the
				// input queue fills and the block stalls its input.
				holds_asked++;
				run_mixed_set(12);
			end
			if (phase == 3)
				wait_drained();
			while (boxes_sent - first_box < PHASE_ITEMS)
				run_mixed_set($urandom_range(4, 40));
		end

		// Close with a fresh frame so the index restarts from zero.
		wait_drained();
		offer_box(make_box(1'b1, 0, 0, 64, 64));

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/gbn_pkg.sv
rtl/core/gbn_front.sv
rtl/core/gbn_iou.sv
rtl/core/gbn_back.sv
rtl/core/greedy_box_nms.sv
verif/nms_checker.sv
verif/testbench.sv
